FILE: rtl/core/deq_pkg.sv
package deq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  // port field widths
  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int TOTAL_W  = 5;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 32;
  localparam int USER_W   = 8;
  localparam int OUT_W    = 80;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rot;
    logic enc;
    logic load;
  } deq_cmd_t;

endpackage

FILE: rtl/core/deq_datapath.sv
module deq_datapath
  import deq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  deq_cmd_t             cmd,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [IN_W-1:0]      in_value,
  output logic [OUT_W-1:0]     result
);

  logic [FUNC_W-1:0]     func_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] cells [CAPACITY];
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      count;
  status_t               status_q;
  logic [CAPACITY-1:0]   hits;
  logic [CAPACITY-1:0]   rot;
  logic                  hit_q;
  logic [IDX_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] front_q;
  logic [DATA_WIDTH-1:0] back_q;

  logic [IDX_W-1:0]      head_next;
  logic [CNT_W-1:0]      count_next;
  status_t               status_next;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [CAPACITY-1:0]   hits_next;
  logic [CAPACITY-1:0]   rot_next;
  logic                  found;
  logic [IDX_W-1:0]      pos_next;
  logic [IDX_W-1:0]      back_addr;
  logic                  empty;
  logic [WORD_W-1:0]     front_word;
  logic [WORD_W-1:0]     back_word;

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
    return IDX_W'(s);
  endfunction

  // operation decode against the current state
  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = ST_OK;
    wr_en       = 1'b0;
    wr_addr     = head;
    unique case (func_q)
      OP_PUSH_FRONT: begin
        if (count >= CNT_W'(CAPACITY)) begin
          status_next = ST_OVER;
        end else begin
          head_next  = (head == '0) ? IDX_W'(CAPACITY - 1) : head - 1'b1;
          wr_en      = 1'b1;
          wr_addr    = head_next;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count >= CNT_W'(CAPACITY)) begin
          status_next = ST_OVER;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = wrap_add(head, count);
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          status_next = ST_UNDER;
        end else begin
          head_next  = wrap_add(head, CNT_W'(1));
          count_next = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          status_next = ST_UNDER;
        end else begin
          count_next = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // one comparator per cell; a cell only counts when it lies inside the live window
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] offset;
      slot = IDX_W'(i);
      if (slot >= head) offset = CNT_W'(slot - head);
      else offset = CNT_W'(SUM_W'(slot) + SUM_W'(CAPACITY) - SUM_W'(head));
      hits_next[i] = (offset < count) && (cells[i] == val_q);
    end
  end

  // realign match vector so bit 0 is the front entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      rot_next[i] = hits[wrap_add(head, CNT_W'(i))];
    end
  end

  always_comb begin
    found    = 1'b0;
    pos_next = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (rot[i]) begin
        found    = 1'b1;
        pos_next = IDX_W'(i);
      end
    end
  end

  assign back_addr  = wrap_add(head, (count == '0) ? '0 : count - 1'b1);
  assign empty      = (count == '0);
  assign front_word = empty ? '0 : WORD_W'(front_q);
  assign back_word  = empty ? '0 : WORD_W'(back_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= in_func;
      val_q  <= DATA_WIDTH'(in_value);
    end
    if (cmd.exec) begin
      status_q <= status_next;
      hits     <= hits_next;
      if (wr_en) cells[wr_addr] <= val_q;
    end
    if (cmd.rot) begin
      rot     <= rot_next;
      front_q <= cells[head];
    end
    if (cmd.enc) begin
      hit_q  <= found && (func_q == OP_SEARCH);
      pos_q  <= (found && (func_q == OP_SEARCH)) ? pos_next : '0;
      back_q <= cells[back_addr];
    end
    if (cmd.load) begin
      result <= {3'b000, status_q, POS_W'(pos_q), hit_q, empty, TOTAL_W'(count),
                 back_word, front_word};
    end
  end

endmodule

FILE: rtl/core/deq_ctrl.sv
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output deq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROT,
    S_ENC,
    S_DONE
  } state_t;

  state_t state;
  logic   ready;
  logic   out_valid;

  always_comb begin
    cmd.capture = (state == S_IDLE) && ready && s_tvalid;
    cmd.exec    = (state == S_EXEC);
    cmd.rot     = (state == S_ROT);
    cmd.enc     = (state == S_ENC);
    cmd.load    = (state == S_DONE) && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            ready <= 1'b0;
            state <= S_EXEC;
          end else begin
            ready <= 1'b1;
          end
        end
        S_EXEC: state <= S_ROT;
        S_ROT:  state <= S_ENC;
        S_ENC:  state <= S_DONE;
        S_DONE: begin
          if (cmd.load) begin
            ready <= 1'b1;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign s_tready = ready;
  assign m_tvalid = out_valid;

endmodule

FILE: rtl/core/double_ended_queue_with_search_top.sv
// Bounded double-ended queue of data words with a content search.
// Input stream: one transaction per operation. s_tuser carries the operation
// code (push front, push back, pop front, pop back, search, clear), s_tdata
// the word to push or the value to look for.
// Output stream: one transaction per operation with the front and back words,
// the word count, an empty flag, the search hit and its position from the
// front, and a status code (ok, underflow, overflow).
// Sequencing: a new operation is taken only once the previous result has been
// loaded into the output register. The controller walks each operation
// through update, rotate-match, priority-encode and output-load steps; the
// search compares every cell in parallel in the update step, then realigns
// and encodes the match vector in the rotate-match and priority-encode steps.
// The output register holds a finished result while m_tready is low; the
// next operation is taken and processed meanwhile, and waits at the load step
// until the held result has gone.
// Reset (rst, synchronous) empties the queue; s_tready rises in the cycle after
// reset is released. Storage contents are not cleared, only the head and count.
module double_ended_queue_with_search_top
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [31:0] value
  input  logic [USER_W-1:0] s_tuser,   // [2:0] func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // front_value, back_value, entry_total, is_empty,
                                       // hit, hit_position, status (low to high)
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  deq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_func  (s_tuser[FUNC_W-1:0]),
    .in_value (s_tdata),
    .result   (m_tdata)
  );

endmodule

FILE: dv/deque_result_checker.sv
`timescale 1ns / 100ps

module deque_result_checker
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic [USER_W-1:0] s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                hits,
  output int                overflows,
  output int                underflows
);

  // m_tdata fields, lowest bit first from the bottom of the struct
  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     hit_pos;
    logic                 hit;
    logic                 is_empty;
    logic [TOTAL_W-1:0]   total;
    logic [WORD_W-1:0]    back;
    logic [WORD_W-1:0]    front;
  } deque_view_t;

  localparam int VIEW_W = $bits(deque_view_t);

  logic [WORD_W-1:0] ring_words [CAPACITY];
  int                ring_head;
  int                ring_count;
  deque_view_t       predicted_results [$];
  deque_view_t       want;
  deque_view_t       got;

  initial begin
    errors     = 0;
    pending    = 0;
    checked    = 0;
    hits       = 0;
    overflows  = 0;
    underflows = 0;
    ring_head  = 0;
    ring_count = 0;
  end

  function automatic int ring_slot(int offset);
    return (ring_head + offset) % CAPACITY;
  endfunction

  // Updates the shadow ring and returns what the block should report.
  function automatic deque_view_t apply_deque_op(logic [FUNC_W-1:0] func,
                                                 logic [WORD_W-1:0] word);
    deque_view_t res;
    int          k;
    res = '0;
    res.status = ST_OK;
    case (func)
      OP_PUSH_FRONT: begin
        if (ring_count >= CAPACITY) begin
          res.status = ST_OVER;
        end else begin
          ring_head = (ring_head == 0) ? CAPACITY - 1 : ring_head - 1;
          ring_words[ring_head] = word;
          ring_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_count >= CAPACITY) begin
          res.status = ST_OVER;
        end else begin
          ring_words[ring_slot(ring_count)] = word;
          ring_count++;
        end
      end
      OP_POP_FRONT: begin
        if (ring_count == 0) begin
          res.status = ST_UNDER;
        end else begin
          ring_head = ring_slot(1);
          ring_count--;
        end
      end
      OP_POP_BACK: begin
        if (ring_count == 0) res.status = ST_UNDER;
        else ring_count--;
      end
      OP_SEARCH: begin
        for (k = 0; k < ring_count; k++) begin
          if (ring_words[ring_slot(k)] == word) begin
            res.hit     = 1'b1;
            res.hit_pos = k[POS_W-1:0];
            break;
          end
        end
      end
      OP_CLEAR: begin
        ring_head  = 0;
        ring_count = 0;
      end
      default: ;  // spare codes leave the queue alone
    endcase
    if (ring_count != 0) begin
      res.front = ring_words[ring_head];
      res.back  = ring_words[ring_slot(ring_count - 1)];
    end
    res.total    = ring_count[TOTAL_W-1:0];
    res.is_empty = (ring_count == 0);
    return res;
  endfunction

  task automatic note_mismatch(string field, logic [WORD_W-1:0] seen,
                               logic [WORD_W-1:0] wanted);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
             seen, wanted);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ring_head  = 0;
      ring_count = 0;
      predicted_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        want = apply_deque_op(s_tuser[FUNC_W-1:0], s_tdata[WORD_W-1:0]);
        predicted_results.insert(predicted_results.size(), want);
        if (want.hit) hits++;
        if (want.status == ST_OVER) overflows++;
        if (want.status == ST_UNDER) underflows++;
      end
      if (m_tvalid && m_tready) begin
        got = deque_view_t'(m_tdata[VIEW_W-1:0]);
        if (predicted_results.size() == 0) begin
          $display("[%0t] result transaction with nothing outstanding", $realtime);
          errors++;
        end else begin
          want = predicted_results[0];
          predicted_results.delete(0);
          checked++;
          if (got.front !== want.front) note_mismatch("front_value", got.front, want.front);
          if (got.back !== want.back) note_mismatch("back_value", got.back, want.back);
          if (got.total !== want.total)
            note_mismatch("entry_total", WORD_W'(got.total), WORD_W'(want.total));
          if (got.is_empty !== want.is_empty)
            note_mismatch("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
          if (got.hit !== want.hit)
            note_mismatch("hit", WORD_W'(got.hit), WORD_W'(want.hit));
          if (got.hit_pos !== want.hit_pos)
            note_mismatch("hit_position", WORD_W'(got.hit_pos), WORD_W'(want.hit_pos));
          if (got.status !== want.status)
            note_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
        end
      end
    end
    pending = predicted_results.size();
  end

endmodule

FILE: dv/double_ended_queue_with_search_top_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_with_search_top_tb
  import deq_pkg::*;
();

  localparam logic [FUNC_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_PER_PHASE = 250;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic [USER_W-1:0] s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  int errors, pending, checked, hits, overflows, underflows;
  int send_idle_pct = 12;
  int recv_idle_pct = 55;
  int ops_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_with_search_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  deque_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .hits       (hits),
    .overflows  (overflows),
    .underflows (underflows)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {{(USER_W-FUNC_W){1'b0}}, func};
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ops_sent++;
    @(negedge clk);
  endtask

  // Drifts between filling and draining so both full and empty are reached.
  task automatic random_phase(input int n);
    int                k;
    int                pick;
    int                push_pct;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] word;
    for (k = 0; k < n; k++) begin
      push_pct = ((k / 48) % 2 == 0) ? 80 : 20;
      pick = $urandom_range(99);
      if (pick < 2) func = OP_CLEAR;
      else if (pick < 4) func = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      else if (pick < 20) func = OP_SEARCH;
      else if ($urandom_range(99) < push_pct)
        func = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        func = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      // small pool so searches find something; full-range words for bit toggles
      case ($urandom_range(9))
        0, 1, 2, 3, 4: word = $urandom_range(15);
        5:             word = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        6:             word = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default:       word = $urandom;
      endcase
      send_op(func, word);
    end
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty- and full-queue corner cases
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_SEARCH, 32'h0);
    send_op(OP_PUSH_BACK, 32'h0);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);  // head wraps below zero
    send_op(OP_SPARE_LO, 32'h1234_5678);
    send_op(OP_SPARE_HI, 32'h1234_5678);
    send_op(OP_SEARCH, 32'h0);
    send_op(OP_SEARCH, 32'h1234_5678);
    for (k = 1; k <= 14; k++)
      send_op((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, k * 32'h1111_1111);
    send_op(OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_op(OP_PUSH_BACK, 32'hDEAD_BEEF);
    send_op(OP_SEARCH, 32'hEEEE_EEEE);      // last slot
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_CLEAR, 32'h0);

    random_phase(RANDOM_PER_PHASE);
    send_idle_pct = 55;
    recv_idle_pct = 12;
    random_phase(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d operations, %0d results compared", ops_sent, checked);
    $display("Saw %0d search hits, %0d overflows, %0d underflows",
             hits, overflows, underflows);
    if (errors == 0 && pending == 0) begin
      $display("double_ended_queue_with_search_top test passed");
    end else begin
      $display("double_ended_queue_with_search_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending);
    $display("double_ended_queue_with_search_top test failed");
    $finish;
  end

endmodule
